// File: hdl/gdo_pkg.sv
// gdo_pkg: shared types, control word layout and calendar tables for the
// gregorian date offset block; used by gdo_seq and gregorian_date_offset
`default_nettype none

package gdo_pkg;

  // datapath operations selected by the control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_MOD,
    OP_CLAMP,
    OP_ORD,
    OP_YEAR,
    OP_MINIT,
    OP_MONTH,
    OP_SETDAY,
    OP_DOY,
    OP_OUT,
    OP_RESTORE
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_IDLE,
    C_YBUSY,
    C_MBUSY,
    C_OOR
  } cond_t;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic start;
    logic ybusy;
    logic mbusy;
    logic oor;
  } stat_t;

  localparam logic [13:0] YEAR_MIN = 14'd1;
  localparam logic [13:0] YEAR_MAX = 14'd9999;
  localparam logic [3:0]  MONTH_MAX = 4'd12;

  // days before the first of month m in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd2:                    r = leap ? 5'd29 : 5'd28;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

  // leap rule from residues: year mod 4, year mod 100, (year / 100) mod 4
  function automatic logic leap_cur(input logic [1:0] c4, input logic [6:0] c100,
                                    input logic [1:0] cq);
    return (c4 == 2'd0) && ((c100 != 7'd0) || (cq == 2'd0));
  endfunction

  function automatic logic leap_prev(input logic [1:0] c4, input logic [6:0] c100,
                                     input logic [1:0] cq);
    return (c4 == 2'd1) && ((c100 != 7'd1) || (cq == 2'd0));
  endfunction

  function automatic logic leap_next(input logic [1:0] c4, input logic [6:0] c100,
                                     input logic [1:0] cq);
    return (c4 == 2'd3) && ((c100 != 7'd99) || (cq == 2'd3));
  endfunction

endpackage

`default_nettype wire

// File: hdl/gdo_seq.sv
// gdo_seq: step counter and control store for the date offset datapath
// depends on gdo_pkg for the control word and status types
`default_nettype none

module gdo_seq (
  input  wire            clk,
  input  wire            rst,
  input  gdo_pkg::stat_t stat,
  output gdo_pkg::ctrl_t ctrl,
  output logic           busy
);

  // program store
  function automatic gdo_pkg::ctrl_t rom(input gdo_pkg::pc_t a);
    gdo_pkg::ctrl_t w;
    unique case (a)
      4'd0:    w = '{gdo_pkg::OP_LOAD,    gdo_pkg::C_IDLE,   4'd0};
      4'd1:    w = '{gdo_pkg::OP_DIV,     gdo_pkg::C_NEVER,  4'd0};
      4'd2:    w = '{gdo_pkg::OP_MOD,     gdo_pkg::C_NEVER,  4'd0};
      4'd3:    w = '{gdo_pkg::OP_CLAMP,   gdo_pkg::C_NEVER,  4'd0};
      4'd4:    w = '{gdo_pkg::OP_ORD,     gdo_pkg::C_NEVER,  4'd0};
      4'd5:    w = '{gdo_pkg::OP_YEAR,    gdo_pkg::C_YBUSY,  4'd5};
      4'd6:    w = '{gdo_pkg::OP_MINIT,   gdo_pkg::C_OOR,    4'd11};
      4'd7:    w = '{gdo_pkg::OP_MONTH,   gdo_pkg::C_MBUSY,  4'd7};
      4'd8:    w = '{gdo_pkg::OP_SETDAY,  gdo_pkg::C_NEVER,  4'd0};
      4'd9:    w = '{gdo_pkg::OP_DOY,     gdo_pkg::C_NEVER,  4'd0};
      4'd10:   w = '{gdo_pkg::OP_OUT,     gdo_pkg::C_ALWAYS, 4'd0};
      4'd11:   w = '{gdo_pkg::OP_RESTORE, gdo_pkg::C_ALWAYS, 4'd9};
      default: w = '{gdo_pkg::OP_NOP,     gdo_pkg::C_ALWAYS, 4'd0};
    endcase
    return w;
  endfunction

  gdo_pkg::pc_t pc;
  gdo_pkg::pc_t pc_next;
  logic         take;

  assign ctrl = rom(pc);
  assign busy = (pc != '0);

  // condition select
  always_comb begin
    unique case (ctrl.cond)
      gdo_pkg::C_NEVER:  take = 1'b0;
      gdo_pkg::C_ALWAYS: take = 1'b1;
      gdo_pkg::C_IDLE:   take = !stat.start;
      gdo_pkg::C_YBUSY:  take = stat.ybusy;
      gdo_pkg::C_MBUSY:  take = stat.mbusy;
      gdo_pkg::C_OOR:    take = stat.oor;
      default:           take = 1'b1;
    endcase
    pc_next = take ? ctrl.target : pc + 1'b1;
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/gregorian_date_offset.sv
// gregorian_date_offset: top level, calendar datapath driven by gdo_seq
// depends on gdo_pkg and gdo_seq
`default_nettype none

// Adds a signed day offset to a Gregorian date. An item is taken when start
// is high and busy is low; busy stays high until the result is written, and
// done then marks the result ports for one cycle (the receiver cannot stall,
// so capture it then). The sequencer steps one year per cycle across the Y
// whole years crossed (at most about 90 for a 16-bit offset), then one month
// per cycle across the M months walked in the final year (at most 11). If the
// result year leaves 1..9999, out_of_range is set and the clamped starting
// date is returned.
module gregorian_date_offset (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  output logic              busy,
  input  wire        [4:0]  in_day,
  input  wire        [3:0]  in_month,
  input  wire        [13:0] in_year,
  input  wire signed [15:0] offset_days,
  output logic              done,
  output logic       [4:0]  out_day,
  output logic       [3:0]  out_month,
  output logic       [13:0] out_year,
  output logic              leap_year,
  output logic       [8:0]  days_to_new_year,
  output logic       [8:0]  days_to_christmas,
  output logic              out_of_range
);

  gdo_pkg::ctrl_t ctrl;
  gdo_pkg::stat_t stat;

  // working date and year residues
  logic [4:0]         dy;
  logic [3:0]         mo;
  logic [13:0]        yr;
  logic signed [16:0] t;
  logic signed [15:0] offs;
  logic [1:0]         c4;
  logic [6:0]         c100;
  logic [1:0]         cq;
  logic [7:0]         q100;
  logic [8:0]         doy;
  logic               oor;

  // starting date kept for the out of range case
  logic [4:0]  ds;
  logic [3:0]  ms;
  logic [13:0] ys;
  logic [1:0]  s4;
  logic [6:0]  s100;
  logic [1:0]  sq;

  logic               leap;
  logic               leap_p;
  logic               leap_n;
  logic [8:0]         ylen;
  logic [8:0]         ylen_p;
  logic [4:0]         mlen;
  logic [26:0]        prod;
  logic [13:0]        qx100;
  logic [13:0]        rem100;
  logic [8:0]         doy_cur;
  logic signed [16:0] ord;
  logic               below;
  logic               above;
  logic               fault;
  logic [9:0]         xmas;
  logic [9:0]         to_x;
  logic [9:0]         to_ny;

  gdo_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl),
    .busy (busy)
  );

  // calendar terms of the working year
  always_comb begin
    leap    = gdo_pkg::leap_cur(c4, c100, cq);
    leap_p  = gdo_pkg::leap_prev(c4, c100, cq);
    leap_n  = gdo_pkg::leap_next(c4, c100, cq);
    ylen    = leap ? 9'd366 : 9'd365;
    ylen_p  = leap_p ? 9'd366 : 9'd365;
    mlen    = gdo_pkg::month_len(mo, leap);
    prod    = {13'd0, yr} * 27'd5243;
    qx100   = {6'd0, q100} * 14'd100;
    rem100  = yr - qx100;
    doy_cur = gdo_pkg::cum_days(mo) + {8'd0, leap && (mo > 4'd2)} + {4'd0, dy};
    ord     = $signed({8'd0, doy_cur}) - 17'sd1 + 17'(offs);
    below   = t < 17'sd0;
    above   = !below && (t >= $signed({8'd0, ylen}));
    fault   = (below && (yr == gdo_pkg::YEAR_MIN)) ||
              (above && (yr == gdo_pkg::YEAR_MAX));
    xmas    = 10'd359 + {9'd0, leap};
    to_ny   = {1'b0, ylen} - {1'b0, doy} + 10'd1;
    if ({1'b0, doy} < xmas) begin
      to_x = xmas - {1'b0, doy};
    end else begin
      to_x = {1'b0, ylen} - {1'b0, doy} + 10'd359 + {9'd0, leap_n};
    end
  end

  // status back to the sequencer
  assign stat.start = start;
  assign stat.ybusy = (below || above) && !fault;
  assign stat.mbusy = (mo < gdo_pkg::MONTH_MAX) && (t >= $signed({12'd0, mlen}));
  assign stat.oor   = oor;

  // datapath registers and result port
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      oor  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (ctrl.op)
        gdo_pkg::OP_LOAD: begin
          if (start) begin
            dy   <= in_day;
            mo   <= (in_month == 4'd0) ? 4'd1 :
                    (in_month > gdo_pkg::MONTH_MAX) ? gdo_pkg::MONTH_MAX : in_month;
            yr   <= (in_year == 14'd0) ? gdo_pkg::YEAR_MIN :
                    (in_year > gdo_pkg::YEAR_MAX) ? gdo_pkg::YEAR_MAX : in_year;
            offs <= offset_days;
            oor  <= 1'b0;
          end
        end
        gdo_pkg::OP_DIV: begin
          q100 <= prod[26:19];
        end
        gdo_pkg::OP_MOD: begin
          c4   <= yr[1:0];
          c100 <= rem100[6:0];
          cq   <= q100[1:0];
        end
        gdo_pkg::OP_CLAMP: begin
          if (dy == 5'd0) begin
            dy <= 5'd1;
          end else if (dy > mlen) begin
            dy <= mlen;
          end
        end
        gdo_pkg::OP_ORD: begin
          t    <= ord;
          ds   <= dy;
          ms   <= mo;
          ys   <= yr;
          s4   <= c4;
          s100 <= c100;
          sq   <= cq;
        end
        gdo_pkg::OP_YEAR: begin
          if (fault) begin
            oor <= 1'b1;
          end else if (below) begin
            // step back into the previous year
            yr   <= yr - 14'd1;
            t    <= t + $signed({8'd0, ylen_p});
            c4   <= c4 - 2'd1;
            c100 <= (c100 == 7'd0) ? 7'd99 : c100 - 7'd1;
            if (c100 == 7'd0) begin
              cq <= cq - 2'd1;
            end
          end else if (above) begin
            // step forward past a whole year
            yr   <= yr + 14'd1;
            t    <= t - $signed({8'd0, ylen});
            c4   <= c4 + 2'd1;
            c100 <= (c100 == 7'd99) ? 7'd0 : c100 + 7'd1;
            if (c100 == 7'd99) begin
              cq <= cq + 2'd1;
            end
          end
        end
        gdo_pkg::OP_MINIT: begin
          mo <= 4'd1;
        end
        gdo_pkg::OP_MONTH: begin
          if (stat.mbusy) begin
            t  <= t - $signed({12'd0, mlen});
            mo <= mo + 4'd1;
          end
        end
        gdo_pkg::OP_SETDAY: begin
          dy <= t[4:0] + 5'd1;
        end
        gdo_pkg::OP_DOY: begin
          doy <= doy_cur;
        end
        gdo_pkg::OP_RESTORE: begin
          dy   <= ds;
          mo   <= ms;
          yr   <= ys;
          c4   <= s4;
          c100 <= s100;
          cq   <= sq;
        end
        gdo_pkg::OP_OUT: begin
          done              <= 1'b1;
          out_day           <= dy;
          out_month         <= mo;
          out_year          <= yr;
          leap_year         <= leap;
          days_to_new_year  <= to_ny[8:0];
          days_to_christmas <= to_x[8:0];
          out_of_range      <= oor;
        end
        default: begin
        end
      endcase
    end
  end

  // result only after a busy cycle, and never while still busy
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result strobe outside a finished item");

  // an accepted item keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  // result date fields always land in their legal ranges, and both day counts are nonzero
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((out_day != 5'd0) && (out_month != 4'd0) && (out_month <= 4'd12) &&
              (out_year != 14'd0) && (out_year <= 14'd9999) &&
              (days_to_new_year != 9'd0) && (days_to_christmas != 9'd0)))
    else $error("result field out of range");

endmodule

`default_nettype wire
